### design/perceptron_neuron_delta_rule_defines.svh
// Assertion macros shared by the perceptron neuron checker.
`ifndef PERCEPTRON_NEURON_DELTA_RULE_DEFINES_SVH
`define PERCEPTRON_NEURON_DELTA_RULE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PNDR_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PNDR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/pndr_pkg.sv
// Shared types, codes and helpers for the perceptron neuron.
package pndr_pkg;

   localparam logic [1:0] FUNC_LOAD_W = 2'd0;
   localparam logic [1:0] FUNC_LOAD_B = 2'd1;
   localparam logic [1:0] FUNC_FWD    = 2'd2;
   localparam logic [1:0] FUNC_UPD    = 2'd3;

   localparam int          Q_DEPTH   = 4;
   localparam int          Q_PTR_W   = 2;
   localparam logic [14:0] ETA_RESET = 15'd41;

   typedef struct packed {
      logic [1:0]          func;
      logic signed [15:0]  x_value;
      logic signed [15:0]  delta;
      logic                last;
      logic                in_range;
      logic                mismatch;
   } cmd_type;

   function automatic logic signed [15:0] sat16(input logic signed [24:0] v);
      logic signed [15:0] r;
      if (v > 25'sd32767) begin
         r = 16'sd32767;
      end else if (v < -25'sd32768) begin
         r = -16'sd32768;
      end else begin
         r = $signed(v[15:0]);
      end
      return r;
   endfunction

endpackage

### design/pndr_front.sv
// Front end: accepts words, tracks element index and count errors, classifies.
module pndr_front #(
   parameter int N_INPUTS = 16,
   parameter int AW       = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic [1:0]              req_func,
   input  logic signed [15:0]      req_x_value,
   input  logic signed [15:0]      req_delta,
   input  logic                    req_last,
   input  logic                    q_full,
   output logic                    q_push,
   output pndr_pkg::cmd_type       q_cmd,
   output logic [AW-1:0]           q_addr
);
   import pndr_pkg::*;

   localparam int IW = $clog2(N_INPUTS + 1);

   logic [IW-1:0] idx_ff, idx_in;
   logic          err_ff, err_in;
   logic          in_range;

   assign req_full = q_full;
   assign q_push   = req_push && !q_full;
   assign in_range = idx_ff < IW'(N_INPUTS);
   assign q_addr   = idx_ff[AW-1:0];

   always_comb begin
      q_cmd.func     = req_func;
      q_cmd.x_value  = req_x_value;
      q_cmd.delta    = req_delta;
      q_cmd.last     = req_last;
      q_cmd.in_range = in_range;
      q_cmd.mismatch = err_ff || !in_range || (idx_ff != IW'(N_INPUTS - 1));
   end

   always_comb begin
      idx_in = idx_ff;
      err_in = err_ff;
      if (q_push && req_func != FUNC_LOAD_B) begin
         if (req_last) begin
            idx_in = '0;
            err_in = 1'b0;
         end else if (in_range) begin
            idx_in = idx_ff + IW'(1);
         end else begin
            err_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         err_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         err_ff <= err_in;
      end
   end

endmodule

### design/pndr_queue.sv
// Short command queue between the front and back ends.
module pndr_queue #(
   parameter int WIDTH = 40
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   import pndr_pkg::*;

   logic [WIDTH-1:0]   slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_W:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = count_ff == (Q_PTR_W + 1)'(Q_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + Q_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (Q_PTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (Q_PTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### design/pndr_back.sv
// Back end: weight memory, multiply-accumulate, delta-rule update, result register.
module pndr_back #(
   parameter int N_INPUTS = 16,
   parameter int AW       = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [14:0]              csr_wdata,
   input  logic                     q_empty,
   output logic                     q_pop,
   input  pndr_pkg::cmd_type        q_cmd,
   input  logic [AW-1:0]            q_addr,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic signed [39:0]       rsp_sum_out,
   output logic                     rsp_status
);
   import pndr_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_MUL2 = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic signed [15:0] weight_mem [N_INPUTS];
   logic [N_INPUTS-1:0] wvalid_ff, wvalid_in;

   logic [1:0]          state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [AW-1:0]       addr_ff, addr_in;
   logic signed [15:0]  rd_ff;
   logic                rdv_ff;
   logic signed [31:0]  wx_ff, wx_in, ed_ff, ed_in;
   logic signed [47:0]  edx_ff, edx_in;
   logic signed [39:0]  acc_ff, acc_in;
   logic signed [15:0]  bias_ff, bias_in;
   logic [14:0]         eta_ff, eta_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [39:0]  sum_ff, sum_in;
   logic                status_ff, status_in;

   logic                rd_en, mem_we, out_free, emit;
   logic signed [15:0]  w_eff, new_w, new_b, mem_wdata;
   logic signed [47:0]  step_w_sum;
   logic signed [23:0]  step_w;
   logic signed [32:0]  step_b_sum;
   logic signed [20:0]  step_b;
   logic signed [39:0]  acc_sum, acc_cur, bias40, sum_val;

   assign rsp_empty   = !rsp_valid_ff;
   assign rsp_sum_out = sum_ff;
   assign rsp_status  = status_ff;
   assign out_free    = !rsp_valid_ff || rsp_pop;

   assign w_eff      = rdv_ff ? rd_ff : 16'sd0;
   assign step_w_sum = edx_ff + 48'sd8388608;
   assign step_w     = $signed(step_w_sum[47:24]);
   assign new_w      = sat16(25'(w_eff) - 25'(step_w));
   assign step_b_sum = 33'(ed_ff) + 33'sd2048;
   assign step_b     = $signed(step_b_sum[32:12]);
   assign new_b      = sat16(25'(bias_ff) - 25'(step_b));
   assign acc_sum    = acc_ff + 40'(wx_ff);
   assign acc_cur    = (cmd_ff.in_range && cmd_ff.func == FUNC_FWD) ? acc_sum : acc_ff;
   assign bias40     = $signed({{12{bias_ff[15]}}, bias_ff, 12'd0});
   assign sum_val    = acc_cur + bias40;
   assign emit       = cmd_ff.last && cmd_ff.func != FUNC_LOAD_B;
   assign mem_wdata  = (cmd_ff.func == FUNC_LOAD_W) ? cmd_ff.x_value : new_w;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      addr_in      = addr_ff;
      wx_in        = wx_ff;
      ed_in        = ed_ff;
      edx_in       = edx_ff;
      acc_in       = acc_ff;
      bias_in      = bias_ff;
      eta_in       = csr_we ? csr_wdata : eta_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      sum_in       = sum_ff;
      status_in    = status_ff;
      wvalid_in    = wvalid_ff;
      rd_en        = 1'b0;
      mem_we       = 1'b0;
      q_pop        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               rd_en    = 1'b1;
               cmd_in   = q_cmd;
               addr_in  = q_addr;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            wx_in    = 32'(w_eff) * 32'(cmd_ff.x_value);
            ed_in    = 32'($signed({1'b0, eta_ff})) * 32'(cmd_ff.delta);
            state_in = S_MUL2;
         end
         S_MUL2: begin
            edx_in   = 48'(ed_ff) * 48'(cmd_ff.x_value);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!emit || out_free) begin
               state_in = S_IDLE;
               if (cmd_ff.in_range &&
                   (cmd_ff.func == FUNC_LOAD_W || cmd_ff.func == FUNC_UPD)) begin
                  mem_we             = 1'b1;
                  wvalid_in[addr_ff] = 1'b1;
               end
               if (cmd_ff.func == FUNC_LOAD_B) begin
                  bias_in = cmd_ff.x_value;
               end else if (cmd_ff.func == FUNC_UPD && cmd_ff.last && !cmd_ff.mismatch) begin
                  bias_in = new_b;
               end
               if (cmd_ff.func != FUNC_LOAD_B) begin
                  acc_in = cmd_ff.last ? 40'sd0 : acc_cur;
               end
               if (emit) begin
                  rsp_valid_in = 1'b1;
                  sum_in       = (cmd_ff.func == FUNC_FWD) ? sum_val : 40'sd0;
                  status_in    = cmd_ff.mismatch;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         weight_mem[addr_ff] <= mem_wdata;
      end
      if (rd_en) begin
         rd_ff  <= weight_mem[q_addr];
         rdv_ff <= wvalid_ff[q_addr];
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      addr_ff <= addr_in;
      wx_ff   <= wx_in;
      ed_ff   <= ed_in;
      edx_ff  <= edx_in;
      sum_ff  <= sum_in;
      status_ff <= status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wvalid_ff    <= '0;
         acc_ff       <= '0;
         bias_ff      <= '0;
         eta_ff       <= ETA_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wvalid_ff    <= wvalid_in;
         acc_ff       <= acc_in;
         bias_ff      <= bias_in;
         eta_ff       <= eta_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### design/perceptron_neuron_delta_rule.sv
// Top level of the single-neuron perceptron with delta-rule learning.
// Input queue side: drive req_func, req_x_value, req_delta, req_last with req_push;
// a word is taken at a clock edge where req_push is high and req_full is low.
// Functions: load weight, load bias, forward element, update element; a running
// element index advances per non-bias word, and returns to zero on a non-bias req_last.
// Result queue side: while rsp_empty is low, rsp_sum_out/rsp_status hold the
// oldest result; rsp_pop takes it. Only last words of a vector (other than a
// bias load) produce a result.
// Learning rate: csr_we writes csr_wdata into the rate register at once.
// The back-end sequencer runs each word through weight read, two multiplies and
// write-back on one weight memory port, and takes no new word before write-back.
// A 4-word command queue lets the input side keep accepting while the back end
// works or while a result waits.
// Reset: weights and bias read as zero, learning rate 41, queues empty; valid
// bits stand in for a clearing pass, so words are taken right after reset.
// Stall: with a result unpopped the back end holds on the next last word;
// the command queue fills and req_full rises.
module perceptron_neuron_delta_rule #(
   parameter int N_INPUTS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [1:0]         req_func,
   input  logic signed [15:0] req_x_value,
   input  logic signed [15:0] req_delta,
   input  logic               req_last,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [39:0] rsp_sum_out,
   output logic               rsp_status,
   input  logic               csr_we,
   input  logic [14:0]        csr_wdata
);
   import pndr_pkg::*;

   localparam int AW = (N_INPUTS > 1) ? $clog2(N_INPUTS) : 1;
   localparam int CW = $bits(cmd_type);
   localparam int QW = AW + CW;

   logic          f_push, q_full, q_empty, q_pop;
   cmd_type       f_cmd, b_cmd;
   logic [AW-1:0] f_addr, b_addr;
   logic [QW-1:0] q_wdata, q_rdata;

   assign q_wdata = {f_addr, f_cmd};
   assign b_cmd   = cmd_type'(q_rdata[CW-1:0]);
   assign b_addr  = q_rdata[QW-1:CW];

   pndr_front #(.N_INPUTS(N_INPUTS), .AW(AW)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_func    (req_func),
      .req_x_value (req_x_value),
      .req_delta   (req_delta),
      .req_last    (req_last),
      .q_full      (q_full),
      .q_push      (f_push),
      .q_cmd       (f_cmd),
      .q_addr      (f_addr)
   );

   pndr_queue #(.WIDTH(QW)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (f_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   pndr_back #(.N_INPUTS(N_INPUTS), .AW(AW)) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .q_cmd       (b_cmd),
      .q_addr      (b_addr),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_sum_out (rsp_sum_out),
      .rsp_status  (rsp_status)
   );

endmodule

### design/pndr_checker.sv
// Port-level checker for the perceptron neuron, bound to the top level.
`include "perceptron_neuron_delta_rule_defines.svh"

module pndr_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_push,
   input logic               req_full,
   input logic               rsp_empty,
   input logic               rsp_pop,
   input logic signed [39:0] rsp_sum_out,
   input logic               rsp_status
);

   `PNDR_ASSERT_SAME(a_reset_idle, $past(reset), rsp_empty && !req_full, "not idle after reset")
   `PNDR_ASSERT_SAME(a_full_by_push, $rose(req_full), $past(req_push && !req_full), "queue filled without a push")
   `PNDR_ASSERT_SAME(a_empty_by_pop, $rose(rsp_empty), $past(rsp_pop), "result dropped without a pop")
   `PNDR_ASSERT_NEXT(a_rsp_hold, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_sum_out) && $stable(rsp_status), "waiting result changed")

endmodule

bind perceptron_neuron_delta_rule pndr_checker u_pndr_checker (.*);

### dv/tb_top.sv
// Self-checking testbench for the perceptron neuron: load, forward and update vectors.
module tb_top;
   import pndr_pkg::*;

   localparam int NUM_INPUTS  = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE      = 40;
   localparam longint HALF24  = 64'sd1 <<< 23;
   localparam longint HALF12  = 64'sd1 <<< 11;

   typedef struct {
      logic signed [39:0] sum;
      logic               status;
   } neuron_result_type;

   logic               clock;
   logic               reset;
   logic               req_push;
   logic               req_full;
   logic [1:0]         req_func;
   logic signed [15:0] req_x_value;
   logic signed [15:0] req_delta;
   logic               req_last;
   logic               rsp_empty;
   logic               rsp_pop;
   logic signed [39:0] rsp_sum_out;
   logic               rsp_status;
   logic               csr_we;
   logic [14:0]        csr_wdata;

   // neuron state as predicted
   logic signed [15:0] weight_mem [NUM_INPUTS];
   logic signed [15:0] bias_reg;
   logic signed [39:0] acc_reg;
   int unsigned        elem_idx;
   bit                 count_bad;
   logic [14:0]        rate_reg;

   neuron_result_type  pending_results [$];
   neuron_result_type  head;
   int                 errors;
   int                 words_sent;
   int                 results_checked;
   int                 cycle_count;
   int                 send_idle_pct;
   int                 pop_stall_pct;

   perceptron_neuron_delta_rule #(
      .N_INPUTS(NUM_INPUTS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_func    (req_func),
      .req_x_value (req_x_value),
      .req_delta   (req_delta),
      .req_last    (req_last),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_sum_out (rsp_sum_out),
      .rsp_status  (rsp_status),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_pop = ($urandom_range(99) >= pop_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: sum_out %0d status %0d", rsp_sum_out, rsp_status);
            errors++;
         end else begin
            head = pending_results.pop_front();
            results_checked++;
            if (rsp_sum_out !== head.sum) begin
               $error("sum_out mismatch: expected %0d, actual %0d", head.sum, rsp_sum_out);
               errors++;
            end
            if (rsp_status !== head.status) begin
               $error("status mismatch: expected %0d, actual %0d", head.status, rsp_status);
               errors++;
            end
         end
      end
   end

   function automatic logic signed [15:0] clip16(input longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   task automatic apply_word(input logic [1:0] f, input logic signed [15:0] x,
                             input logic signed [15:0] d, input logic l);
      longint            step;
      bit                in_rng;
      neuron_result_type r;
      if (f == FUNC_LOAD_B) begin
         bias_reg = x;
         return;
      end
      in_rng = (elem_idx < NUM_INPUTS);
      if (!in_rng) begin
         count_bad = 1'b1;
      end else begin
         case (f)
            FUNC_LOAD_W: begin
               weight_mem[elem_idx] = x;
            end
            FUNC_FWD: begin
               acc_reg = 40'(longint'(acc_reg)
                             + longint'(weight_mem[elem_idx]) * longint'(x));
            end
            default: begin
               step = (longint'(rate_reg) * longint'(d) * longint'(x) + HALF24) >>> 24;
               weight_mem[elem_idx] = clip16(longint'(weight_mem[elem_idx]) - step);
            end
         endcase
      end
      if (!l) begin
         if (in_rng) elem_idx++;
         return;
      end
      r.status = count_bad || (elem_idx != NUM_INPUTS - 1);
      r.sum = '0;
      if (f == FUNC_FWD) begin
         r.sum = 40'(longint'(acc_reg) + longint'(bias_reg) * 4096);
      end else if (f == FUNC_UPD && !r.status) begin
         step = (longint'(rate_reg) * longint'(d) + HALF12) >>> 12;
         bias_reg = clip16(longint'(bias_reg) - step);
      end
      pending_results.push_back(r);
      acc_reg = '0;
      elem_idx = 0;
      count_bad = 1'b0;
   endtask

   task automatic send_word(input logic [1:0] f, input logic signed [15:0] x,
                            input logic signed [15:0] d, input logic l);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push = 1'b0;
         @(negedge clock);
      end
      req_push    = 1'b1;
      req_func    = f;
      req_x_value = x;
      req_delta   = d;
      req_last    = l;
      do @(posedge clock); while (req_full);
      apply_word(f, x, d, l);
      words_sent++;
   endtask

   task automatic go_quiet();
      @(negedge clock);
      req_push = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_rate(input logic [14:0] v);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = v;
      @(posedge clock);
      rate_reg = v;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic logic signed [15:0] pick_q();
      case ($urandom_range(9))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sh0000;
         3: return 16'($urandom_range(8191)) - 16'sd4096;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [1:0] pick_elem_func();
      case ($urandom_range(2))
         0: return FUNC_LOAD_W;
         1: return FUNC_FWD;
         default: return FUNC_UPD;
      endcase
   endfunction

   task automatic send_vector();
      int         len;
      int         kind;
      bit         mixed;
      logic [1:0] vf;
      logic [1:0] f;
      len = ($urandom_range(99) < 80) ? NUM_INPUTS : $urandom_range(1, NUM_INPUTS + 4);
      kind = $urandom_range(9);
      mixed = (kind == 9);
      vf = (kind < 2) ? FUNC_LOAD_W : (kind < 6) ? FUNC_FWD : FUNC_UPD;
      for (int i = 0; i < len; i++) begin
         f = mixed ? pick_elem_func() : vf;
         if ($urandom_range(39) == 0) begin
            send_word(FUNC_LOAD_B, pick_q(), pick_q(), 1'($urandom));
         end
         send_word(f, pick_q(), pick_q(), i == len - 1);
      end
   endtask

   task automatic test_corner_words();
      send_idle_pct = 0;
      pop_stall_pct = 0;
      // bias load ignores last
      send_word(FUNC_LOAD_B, 16'sh7FFF, 16'sh8000, 1'b1);
      for (int i = 0; i < NUM_INPUTS; i++) begin
         send_word(FUNC_LOAD_W, i[0] ? 16'sh8000 : 16'sh7FFF, 16'sh0000,
                   i == NUM_INPUTS - 1);
      end
      send_word(FUNC_FWD, 16'sh8000, 16'sh7FFF, 1'b1);
      send_word(FUNC_UPD, 16'sh8000, 16'sh8000, 1'b1);
      send_word(FUNC_FWD, 16'sh7FFF, 16'sh0000, 1'b0);
      send_word(FUNC_FWD, 16'sh0000, 16'sh0000, 1'b1);
      send_word(FUNC_LOAD_W, 16'shFFFF, 16'sh0000, 1'b0);
      send_word(FUNC_LOAD_B, 16'sh8000, 16'sh0000, 1'b0);
      send_word(FUNC_FWD, 16'sh7FFF, 16'sh7FFF, 1'b1);
      go_quiet();
   endtask

   task automatic test_stream(input int idle_pct, input int stall_pct,
                              input logic [14:0] rate, input int n_words);
      int start;
      write_rate(rate);
      send_idle_pct = idle_pct;
      pop_stall_pct = stall_pct;
      start = words_sent;
      while (words_sent - start < n_words) send_vector();
      go_quiet();
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_push = 1'b0;
      req_func = FUNC_LOAD_W;
      req_x_value = '0;
      req_delta = '0;
      req_last = 1'b0;
      rsp_pop = 1'b0;
      csr_we = 1'b0;
      csr_wdata = '0;
      send_idle_pct = 0;
      pop_stall_pct = 0;
      errors = 0;
      words_sent = 0;
      results_checked = 0;
      cycle_count = 0;
      foreach (weight_mem[i]) weight_mem[i] = '0;
      bias_reg = '0;
      acc_reg = '0;
      elem_idx = 0;
      count_bad = 1'b0;
      rate_reg = ETA_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_corner_words();
      test_stream(0, 0, 15'd0, 325);
      test_stream(74, 0, 15'h7FFF, 325);
      test_stream(0, 74, 15'($urandom_range(1, 32766)), 325);
      test_stream(7, 7, 15'($urandom_range(1, 400)), 325);

      $display("Streamed %0d words (loads, forward and update vectors, short and long)",
               words_sent);
      $display("Checked %0d results across learning rates 41, 0, max and random",
               results_checked);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
